FILE: design/vpma_pkg.sv
// Shared types, constants and helpers for the planar display memory block.
package vpma_pkg;

    localparam int PLANE_DEPTH_DEF = 65536;
    localparam int OFFSET_W        = 16;
    localparam int BYTE_W          = 8;
    localparam int WORD_W          = 32;
    localparam int CFG_IDX_W       = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_MASK      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN4_MODE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SET_RESET     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_ROTATE   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRAPHICS_MODE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_PLANE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COMPARE = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MASK      = 4'd7;

    // Write modes
    localparam logic [1:0] WMODE_ROTATE = 2'd0;
    localparam logic [1:0] WMODE_LATCH  = 2'd1;
    localparam logic [1:0] WMODE_EXPAND = 2'd2;
    localparam logic [1:0] WMODE_MASKED = 2'd3;

    // Logic functions
    localparam logic [1:0] LOGIC_COPY = 2'd0;
    localparam logic [1:0] LOGIC_AND  = 2'd1;
    localparam logic [1:0] LOGIC_OR   = 2'd2;
    localparam logic [1:0] LOGIC_XOR  = 2'd3;

    typedef struct packed {
        logic [3:0] map_mask;
        logic       chain4_mode;
        logic [7:0] set_reset_control;
        logic [4:0] data_rotate;
        logic [3:0] graphics_mode;
        logic [1:0] read_plane_select;
        logic [7:0] color_compare_control;
        logic [7:0] bit_mask;
    } cfg_t;

    typedef struct packed {
        logic       is_write;
        logic       chain4;
        logic [1:0] plane;
        logic [7:0] data;
    } op_t;

    // Rotate a byte right by 0..7
    function automatic logic [7:0] rot_right(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] t;
        t = {v, v} >> n;
        return t[7:0];
    endfunction

endpackage

FILE: design/vga_planar_memory_access_core.sv
// Planar display memory core: control, configuration registers and latches.
// Flow: an accepted request is read from the plane RAM and finishes in EXEC,
// which waits while an earlier result is untaken; the result is registered.
// A new request is taken only in IDLE. Reset: synchronous, active low; then
// a clearing pass over all PLANE_DEPTH words zeroes the plane RAM while no
// request is taken (config writes still are).
module vga_planar_memory_access_core #(
    parameter int PLANE_DEPTH = vpma_pkg::PLANE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_kind,
    input  logic [vpma_pkg::OFFSET_W-1:0]      s_offset,
    input  logic [vpma_pkg::BYTE_W-1:0]        s_write_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [vpma_pkg::BYTE_W-1:0]        m_read_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vpma_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vpma_pkg::BYTE_W-1:0]        cfg_data
);
    import vpma_pkg::*;

    localparam int AW = $clog2(PLANE_DEPTH);
    localparam logic [17:0] D1 = 18'(PLANE_DEPTH);
    localparam logic [17:0] D2 = 18'(2 * PLANE_DEPTH);
    localparam logic [17:0] D3 = 18'(3 * PLANE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PLANE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]  addr_reg;
    op_t            op_reg;
    cfg_t           cfg_reg;
    logic [31:0]    latch_reg;
    logic           m_valid_reg, m_valid_next;
    logic [7:0]     m_read_data_reg;

    logic           accept;
    logic           done;
    logic [17:0]    off_ext;
    logic [AW-1:0]  planar_addr;
    logic [AW-1:0]  req_addr;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [31:0]    mem_wdata;
    logic [31:0]    mem_rdata;
    logic [31:0]    alu_word;
    logic [7:0]     alu_byte;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign done      = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    // Wrap the offset into the plane depth
    assign off_ext = {2'b00, s_offset};
    always_comb begin
        priority if (off_ext >= D3) begin
            planar_addr = AW'(off_ext - D3);
        end else if (off_ext >= D2) begin
            planar_addr = AW'(off_ext - D2);
        end else if (off_ext >= D1) begin
            planar_addr = AW'(off_ext - D1);
        end else begin
            planar_addr = AW'(off_ext);
        end
    end

    assign req_addr = cfg_reg.chain4_mode ? AW'(s_offset[15:2]) : planar_addr;

    // Plane RAM write: clearing pass or write-back of a finished write request
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = alu_word;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else if (done) begin
            mem_we = op_reg.is_write;
        end
    end

    vpma_plane_ram #(
        .DEPTH (PLANE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (req_addr),
        .rdata (mem_rdata)
    );

    vpma_alu u_alu (
        .cfg       (cfg_reg),
        .op        (op_reg),
        .word      (mem_rdata),
        .latch     (latch_reg),
        .new_word  (alu_word),
        .read_byte (alu_byte)
    );

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Output register: drop on take, load on finish
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (done) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the request
    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg        <= req_addr;
            op_reg.is_write <= s_kind;
            op_reg.chain4   <= cfg_reg.chain4_mode;
            op_reg.plane    <= s_offset[1:0];
            op_reg.data     <= s_write_data;
        end
        if (done) begin
            m_read_data_reg <= alu_byte;
        end
    end

    // Load latches on a planar read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg <= '0;
        end else if (done && !op_reg.is_write && !op_reg.chain4) begin
            latch_reg <= mem_rdata;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.map_mask              <= 4'hf;
            cfg_reg.chain4_mode           <= 1'b0;
            cfg_reg.set_reset_control     <= 8'h00;
            cfg_reg.data_rotate           <= 5'h00;
            cfg_reg.graphics_mode         <= 4'h0;
            cfg_reg.read_plane_select     <= 2'd0;
            cfg_reg.color_compare_control <= 8'h00;
            cfg_reg.bit_mask              <= 8'hff;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MAP_MASK:      cfg_reg.map_mask              <= cfg_data[3:0];
                REG_CHAIN4_MODE:   cfg_reg.chain4_mode           <= cfg_data[0];
                REG_SET_RESET:     cfg_reg.set_reset_control     <= cfg_data;
                REG_DATA_ROTATE:   cfg_reg.data_rotate           <= cfg_data[4:0];
                REG_GRAPHICS_MODE: cfg_reg.graphics_mode         <= cfg_data[3:0];
                REG_READ_PLANE:    cfg_reg.read_plane_select     <= cfg_data[1:0];
                REG_COLOR_COMPARE: cfg_reg.color_compare_control <= cfg_data;
                REG_BIT_MASK:      cfg_reg.bit_mask              <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: design/vpma_plane_ram.sv
// Plane store: one 32-bit word per offset, one write and one registered read port.
module vpma_plane_ram #(
    parameter int DEPTH = vpma_pkg::PLANE_DEPTH_DEF,
    parameter int AW    = vpma_pkg::OFFSET_W
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/vpma_alu.sv
// Graphics controller datapath: read selection, color compare and write modes.
module vpma_alu (
    input  vpma_pkg::cfg_t   cfg,
    input  vpma_pkg::op_t    op,
    input  logic [31:0]      word,
    input  logic [31:0]      latch,
    output logic [31:0]      new_word,
    output logic [7:0]       read_byte
);
    import vpma_pkg::*;

    logic [7:0] rot;
    logic [7:0] cmp_byte;
    logic [31:0] planar_word;
    logic [31:0] chain_word;
    logic [3:0] sr;
    logic [3:0] esr;
    logic [3:0] cmp_color;
    logic [3:0] care;

    assign sr        = cfg.set_reset_control[3:0];
    assign esr       = cfg.set_reset_control[7:4];
    assign cmp_color = cfg.color_compare_control[3:0];
    assign care      = cfg.color_compare_control[7:4];
    assign rot       = rot_right(op.data, cfg.data_rotate[2:0]);

    // Color compare over the four planes of the fetched word
    always_comb begin
        cmp_byte = 8'hff;
        for (int p = 0; p < 4; p++) begin
            if (care[p]) begin
                cmp_byte = cmp_byte & (cmp_color[p] ? word[8*p +: 8] : ~word[8*p +: 8]);
            end
        end
    end

    // Build each plane byte and merge through the map mask
    always_comb begin
        logic [7:0] lat;
        logic [7:0] src;
        logic [7:0] m;
        logic [7:0] fn;
        logic [7:0] outb;
        planar_word = word;
        for (int p = 0; p < 4; p++) begin
            lat = latch[8*p +: 8];
            src = rot;
            m   = cfg.bit_mask;
            unique case (cfg.graphics_mode[1:0])
                WMODE_ROTATE: src = esr[p] ? {8{sr[p]}} : rot;
                WMODE_EXPAND: src = {8{op.data[p]}};
                WMODE_MASKED: begin
                    src = {8{sr[p]}};
                    m   = rot & cfg.bit_mask;
                end
                default: src = rot;
            endcase
            unique case (cfg.data_rotate[4:3])
                LOGIC_AND: fn = src & lat;
                LOGIC_OR:  fn = src | lat;
                LOGIC_XOR: fn = src ^ lat;
                default:   fn = src;
            endcase
            if (cfg.graphics_mode[1:0] == WMODE_LATCH) begin
                outb = lat;
            end else begin
                outb = (fn & m) | (lat & ~m);
            end
            if (cfg.map_mask[p]) begin
                planar_word[8*p +: 8] = outb;
            end
        end
    end

    // Chained write: replace the addressed byte
    always_comb begin
        chain_word = word;
        chain_word[8*op.plane +: 8] = op.data;
    end

    // Select stored word and returned byte
    always_comb begin
        if (op.chain4) begin
            new_word  = chain_word;
            read_byte = op.is_write ? 8'h00 : word[8*op.plane +: 8];
        end else begin
            new_word = planar_word;
            if (op.is_write) begin
                read_byte = 8'h00;
            end else if (cfg.graphics_mode[3]) begin
                read_byte = cmp_byte;
            end else begin
                read_byte = word[8*cfg.read_plane_select +: 8];
            end
        end
    end

endmodule
